FILE: design/gnpb_pkg.sv
// Shared types, codes and constants of the Gaussian noise source.
`default_nettype none
package gnpb_pkg;

    localparam int OUT_WIDTH = 16;
    localparam int FRAC_BITS = 12;

    localparam logic REQ_RESTART = 1'b0;
    localparam logic REQ_DRAW    = 1'b1;

    localparam logic [63:0] PCG_MULT    = 64'd6364136223846793005;
    localparam logic [63:0] PCG_INC     = 64'd1442695040888963407;
    localparam logic [63:0] SEED_OFFSET = 64'h853c49e6748fea9b;
    localparam logic [31:0] TWO_LN2_Q30 = 32'd1488522236;
    localparam logic [31:0] PI_QTR_Q30  = 32'd843314857;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

    // Widths of the radius path and step counts of the datapath loops.
    localparam int V_W   = 36;
    localparam int SQ_W  = 38;
    localparam int RAD_W = 19;
    localparam int SQ_STEPS   = 19;
    localparam int NORM_STEPS = 5;
    localparam int LOG_STEPS  = 30;
    localparam int POW_STEPS  = 9;
    localparam int DIV_STEPS  = 8;

    // Reciprocals for exact floor division of 30-bit values by the
    // factorials of the series: q = (n * ceil(2^(30+l)/d)) >> (30+l).
    localparam logic [31:0] RECIP_6       = 32'(((64'd1 << 33) + 64'd5) / 64'd6);
    localparam logic [31:0] RECIP_24      = 32'(((64'd1 << 35) + 64'd23) / 64'd24);
    localparam logic [31:0] RECIP_120     = 32'(((64'd1 << 37) + 64'd119) / 64'd120);
    localparam logic [31:0] RECIP_720     = 32'(((64'd1 << 40) + 64'd719) / 64'd720);
    localparam logic [31:0] RECIP_5040    = 32'(((64'd1 << 43) + 64'd5039) / 64'd5040);
    localparam logic [31:0] RECIP_40320   = 32'(((64'd1 << 46) + 64'd40319) / 64'd40320);
    localparam logic [31:0] RECIP_362880  = 32'(((64'd1 << 49) + 64'd362879) / 64'd362880);
    localparam logic [31:0] RECIP_3628800 = 32'(((64'd1 << 52) + 64'd3628799) / 64'd3628800);

    typedef struct packed {
        logic req_type;
        logic odd_tail;
    } gnpb_req_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] sample_cos;
        logic signed [OUT_WIDTH-1:0] sample_sin;
        logic                        second_valid;
    } gnpb_res_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD, ST_PCG, ST_NORM_INIT, ST_NORM, ST_LOG_INIT, ST_LOG,
        ST_VLO, ST_VHI, ST_SQ_INIT, ST_SQ, ST_ANG, ST_POW, ST_ACC_INIT, ST_DIV,
        ST_OUT_COS, ST_OUT_SIN, ST_DONE
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_PCG0, OP_PCG1, OP_PCG2, OP_NORM_INIT, OP_NORM,
        OP_LOG_INIT, OP_LOG, OP_VLO, OP_VHI, OP_SQ_INIT, OP_SQ, OP_ANG, OP_POW,
        OP_ACC_INIT, OP_DIV, OP_OUT_COS, OP_OUT_SIN, OP_PUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [4:0] idx;
        logic       take;
    } dp_cmd_t;

endpackage
`default_nettype wire

FILE: design/gaussian_noise_pcg32_box_muller_top.sv
// Top level of the PCG32 / Box-Muller Gaussian noise source.
`default_nettype none
//
//  channel   ports                          moves
//  --------  -----------------------------  -------------------------------------
//  request   s_valid, s_ready, s_req        restart (req_type 0) or draw one pair
//  result    m_valid, m_ready, m_res        cosine/sine samples, second_valid
//  config    cfg_we, cfg_wdata              64-bit seed, written without wait
//
//  A draw request is taken only from idle and runs until its result is pushed; the
//  30 squaring steps of the log2 loop on the shared 32x32 multiplier dominate,
//  followed by the 19-step square root and 17 multiplier steps of the
//  sine/cosine series.
//  A restart request loads the seed, advances the generator once, gives no result.
//  aresetn (synchronous, active low) clears the generator state and the seed.
//  A finished result waits in the output register while the next request is
//  taken; the controller stalls at its last step only if that register is
//  still full.
module gaussian_noise_pcg32_box_muller_top import gnpb_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire gnpb_req_t   s_req,
    output logic             m_valid,
    input  wire logic        m_ready,
    output gnpb_res_t        m_res,
    input  wire logic        cfg_we,
    input  wire logic [63:0] cfg_wdata
);

    dp_cmd_t cmd;

    // Sequence the steps; hold the result until the sink takes it.
    gnpb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_req   (s_req),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Advance the generator, run log, root and series, round and saturate.
    gnpb_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_req     (s_req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .res_data  (m_res)
    );

endmodule
`default_nettype wire

FILE: design/gnpb_dp.sv
// Datapath: PCG state, shared multiplier, log, square root, series and output.
`default_nettype none
module gnpb_dp import gnpb_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire dp_cmd_t     cmd,
    input  wire gnpb_req_t   s_req,
    input  wire logic        cfg_we,
    input  wire logic [63:0] cfg_wdata,
    output gnpb_res_t        res_data
);

    localparam int SH = 46 - FRAC_BITS;
    localparam logic [63:0] RND_HALF = 64'd1 << (SH - 1);
    localparam logic [63:0] MAXV = (64'd1 << (OUT_WIDTH - 1)) - 64'd1;

    logic [63:0] seed_reg, lcg_reg, lo_prod_reg;
    logic [31:0] cross_reg, a_reg, b_reg, n_reg;
    logic [4:0]  lz_reg;
    logic        zero_reg, odd_reg;
    logic [30:0] m_reg;
    logic [29:0] frac_reg;
    logic [V_W-1:0]  v_reg;
    logic [SQ_W-1:0] rem_reg, root_reg, bit_reg;
    logic [2:0]  oct_reg;
    logic [29:0] x_reg, x2_reg, p3_reg, x4_reg, p5_reg, x6_reg, p7_reg, x8_reg;
    logic [29:0] p9_reg, x10_reg;
    logic signed [32:0] s_acc_reg, c_acc_reg;
    logic [OUT_WIDTH-1:0] cos_reg, sin_reg;
    gnpb_res_t out_reg;

    logic [31:0] mul_a, mul_b, xs, pcg_out;
    logic [63:0] prod;
    logic [4:0]  rot;
    logic [35:0] t_val;
    logic [32:0] sq_q;
    logic [SQ_W:0] trial;
    logic [29:0] w_lo, pw_num, quot;
    logic [30:0] r_val, s_cl, c_cl, trig_mag;
    logic        trig_neg;
    logic [31:0] recip;
    logic [5:0]  dshift;
    logic        dsub;
    logic [63:0] rnd;
    logic [OUT_WIDTH-1:0] sat_val;

    function automatic logic [30:0] clamp_unit(input logic signed [32:0] v);
        logic [30:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({2'b00, Q30_ONE})) begin
            r = Q30_ONE;
        end else begin
            r = v[30:0];
        end
        return r;
    endfunction

    // XSH-RR output of the current state
    assign xs      = 32'(((lcg_reg >> 18) ^ lcg_reg) >> 27);
    assign rot     = lcg_reg[63:59];
    assign pcg_out = 32'({xs, xs} >> rot);

    assign t_val = ({24'd0, 6'({1'b0, lz_reg} + 6'd1), 6'd0} << 24) - {6'd0, frac_reg};
    assign w_lo  = {b_reg[28:0], 1'b1};
    // Odd octant: mirror the position inside the octant.
    assign r_val = b_reg[29] ? (Q30_ONE - {1'b0, w_lo}) : {1'b0, w_lo};
    assign sq_q  = prod[62:30];
    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign s_cl  = clamp_unit(s_acc_reg);
    assign c_cl  = clamp_unit(c_acc_reg);

    always_comb begin
        pw_num = p3_reg;
        recip  = RECIP_6;
        dshift = 6'd33;
        dsub   = 1'b1;
        unique case (cmd.idx[2:0])
            3'd0: begin pw_num = p3_reg;  recip = RECIP_6;       dshift = 6'd33; dsub = 1'b1; end
            3'd1: begin pw_num = p5_reg;  recip = RECIP_120;     dshift = 6'd37; dsub = 1'b0; end
            3'd2: begin pw_num = p7_reg;  recip = RECIP_5040;    dshift = 6'd43; dsub = 1'b1; end
            3'd3: begin pw_num = p9_reg;  recip = RECIP_362880;  dshift = 6'd49; dsub = 1'b0; end
            3'd4: begin pw_num = x4_reg;  recip = RECIP_24;      dshift = 6'd35; dsub = 1'b0; end
            3'd5: begin pw_num = x6_reg;  recip = RECIP_720;     dshift = 6'd40; dsub = 1'b1; end
            3'd6: begin pw_num = x8_reg;  recip = RECIP_40320;   dshift = 6'd46; dsub = 1'b0; end
            3'd7: begin pw_num = x10_reg; recip = RECIP_3628800; dshift = 6'd52; dsub = 1'b1; end
            default: begin end
        endcase
    end

    // Octant symmetry: pick sine or cosine magnitude and its sign.
    always_comb begin
        if (cmd.op == OP_OUT_COS) begin
            trig_mag = (oct_reg[0] ^ oct_reg[1]) ? s_cl : c_cl;
            trig_neg = oct_reg[2] ^ oct_reg[1];
        end else begin
            trig_mag = (oct_reg[0] ^ oct_reg[1]) ? c_cl : s_cl;
            trig_neg = oct_reg[2];
        end
    end

    // Shared 32x32 multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_PCG0: begin mul_a = lcg_reg[31:0];  mul_b = PCG_MULT[31:0];  end
            OP_PCG1: begin mul_a = lcg_reg[63:32]; mul_b = PCG_MULT[31:0];  end
            OP_PCG2: begin mul_a = lcg_reg[31:0];  mul_b = PCG_MULT[63:32]; end
            OP_LOG:  begin mul_a = {1'b0, m_reg};  mul_b = {1'b0, m_reg};   end
            OP_VLO:  begin mul_a = {2'b0, t_val[29:0]};  mul_b = TWO_LN2_Q30; end
            OP_VHI:  begin mul_a = {26'b0, t_val[35:30]}; mul_b = TWO_LN2_Q30; end
            OP_ANG:  begin mul_a = {1'b0, r_val};  mul_b = PI_QTR_Q30;      end
            OP_POW: begin
                unique case (cmd.idx)
                    5'd0:    begin mul_a = {2'b0, x_reg};  mul_b = {2'b0, x_reg};  end
                    5'd1:    begin mul_a = {2'b0, x_reg};  mul_b = {2'b0, x2_reg}; end
                    5'd2:    begin mul_a = {2'b0, x2_reg}; mul_b = {2'b0, x2_reg}; end
                    5'd3:    begin mul_a = {2'b0, p3_reg}; mul_b = {2'b0, x2_reg}; end
                    5'd4:    begin mul_a = {2'b0, x4_reg}; mul_b = {2'b0, x2_reg}; end
                    5'd5:    begin mul_a = {2'b0, p5_reg}; mul_b = {2'b0, x2_reg}; end
                    5'd6:    begin mul_a = {2'b0, x6_reg}; mul_b = {2'b0, x2_reg}; end
                    5'd7:    begin mul_a = {2'b0, p7_reg}; mul_b = {2'b0, x2_reg}; end
                    default: begin mul_a = {2'b0, x8_reg}; mul_b = {2'b0, x2_reg}; end
                endcase
            end
            OP_DIV:  begin mul_a = {2'b0, pw_num}; mul_b = recip; end
            OP_OUT_COS, OP_OUT_SIN: begin
                mul_a = {{(32-RAD_W){1'b0}}, root_reg[RAD_W-1:0]};
                mul_b = {1'b0, trig_mag};
            end
            default: begin end
        endcase
    end

    assign prod = {32'd0, mul_a} * {32'd0, mul_b};
    assign quot = 30'(prod >> dshift);

    // Round half away from zero, then saturate.
    assign rnd = (prod + RND_HALF) >> SH;
    always_comb begin
        if (!trig_neg) begin
            sat_val = (rnd > MAXV) ? MAXV[OUT_WIDTH-1:0] : rnd[OUT_WIDTH-1:0];
        end else if (rnd > MAXV + 64'd1) begin
            sat_val = {1'b1, {(OUT_WIDTH-1){1'b0}}};
        end else begin
            sat_val = OUT_WIDTH'(-rnd[OUT_WIDTH-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
            lcg_reg  <= '0;
        end else begin
            if (cfg_we) begin
                seed_reg <= cfg_wdata;
            end
            if (cmd.op == OP_LOAD) begin
                lcg_reg <= seed_reg + SEED_OFFSET;
            end else if (cmd.op == OP_PCG2) begin
                lcg_reg <= lo_prod_reg + {cross_reg + prod[31:0], 32'd0} + PCG_INC;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            odd_reg <= s_req.odd_tail;
        end
        unique case (cmd.op)
            OP_PCG0: begin
                lo_prod_reg <= prod;
                a_reg       <= b_reg;
                b_reg       <= pcg_out;
            end
            OP_PCG1: cross_reg <= prod[31:0];
            OP_NORM_INIT: begin
                n_reg    <= a_reg + 32'd1;
                zero_reg <= (a_reg == '1);
                lz_reg   <= '0;
            end
            OP_NORM: begin
                unique case (cmd.idx)
                    5'd0: if (n_reg[31:16] == '0) begin
                        n_reg <= n_reg << 16; lz_reg <= lz_reg + 5'd16;
                    end
                    5'd1: if (n_reg[31:24] == '0) begin
                        n_reg <= n_reg << 8; lz_reg <= lz_reg + 5'd8;
                    end
                    5'd2: if (n_reg[31:28] == '0) begin
                        n_reg <= n_reg << 4; lz_reg <= lz_reg + 5'd4;
                    end
                    5'd3: if (n_reg[31:30] == '0) begin
                        n_reg <= n_reg << 2; lz_reg <= lz_reg + 5'd2;
                    end
                    default: if (!n_reg[31]) begin
                        n_reg <= n_reg << 1; lz_reg <= lz_reg + 5'd1;
                    end
                endcase
            end
            OP_LOG_INIT: begin
                m_reg    <= n_reg[31:1];
                frac_reg <= '0;
            end
            OP_LOG: begin
                if (sq_q[32:31] != 2'b00) begin
                    m_reg    <= sq_q[31:1];
                    frac_reg <= {frac_reg[28:0], 1'b1};
                end else begin
                    m_reg    <= sq_q[30:0];
                    frac_reg <= {frac_reg[28:0], 1'b0};
                end
            end
            OP_VLO: v_reg <= {5'd0, prod[60:30]};
            OP_VHI: v_reg <= zero_reg ? '0 : prod[V_W-1:0] + v_reg;
            OP_SQ_INIT: begin
                rem_reg  <= {v_reg, 2'b00};
                root_reg <= '0;
                bit_reg  <= SQ_W'(1) << (SQ_W - 2);
            end
            OP_SQ: begin
                if ({1'b0, rem_reg} >= trial) begin
                    rem_reg  <= rem_reg - trial[SQ_W-1:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_ANG: begin
                x_reg   <= prod[59:30];
                oct_reg <= b_reg[31:29];
            end
            OP_POW: begin
                unique case (cmd.idx)
                    5'd0:    x2_reg  <= prod[59:30];
                    5'd1:    p3_reg  <= prod[59:30];
                    5'd2:    x4_reg  <= prod[59:30];
                    5'd3:    p5_reg  <= prod[59:30];
                    5'd4:    x6_reg  <= prod[59:30];
                    5'd5:    p7_reg  <= prod[59:30];
                    5'd6:    x8_reg  <= prod[59:30];
                    5'd7:    p9_reg  <= prod[59:30];
                    default: x10_reg <= prod[59:30];
                endcase
            end
            OP_ACC_INIT: begin
                s_acc_reg <= $signed({3'b000, x_reg});
                c_acc_reg <= $signed({2'b00, Q30_ONE}) - $signed({4'b0000, x2_reg[29:1]});
            end
            OP_DIV: begin
                if (cmd.idx[2]) begin
                    c_acc_reg <= dsub ? c_acc_reg - $signed({3'b000, quot})
                                      : c_acc_reg + $signed({3'b000, quot});
                end else begin
                    s_acc_reg <= dsub ? s_acc_reg - $signed({3'b000, quot})
                                      : s_acc_reg + $signed({3'b000, quot});
                end
            end
            OP_OUT_COS: cos_reg <= sat_val;
            OP_OUT_SIN: sin_reg <= odd_reg ? '0 : sat_val;
            OP_PUSH: begin
                out_reg.sample_cos   <= $signed(cos_reg);
                out_reg.sample_sin   <= $signed(sin_reg);
                out_reg.second_valid <= !odd_reg;
            end
            default: begin end
        endcase
    end

    assign res_data = out_reg;

endmodule
`default_nettype wire

FILE: design/gnpb_ctrl.sv
// Controller: sequences the datapath steps and owns both handshakes.
`default_nettype none
module gnpb_ctrl import gnpb_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire gnpb_req_t s_req,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output dp_cmd_t        cmd
);

    ctrl_state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        draw_reg, draw_next;
    logic        out_valid_reg, out_valid_next;
    logic        push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            draw_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            draw_reg      <= draw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 5'd1;
        draw_next  = draw_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    draw_next  = (s_req.req_type == REQ_DRAW);
                    state_next = (s_req.req_type == REQ_DRAW) ? ST_PCG : ST_LOAD;
                end
            end
            ST_LOAD: begin
                cnt_next   = '0;
                state_next = ST_PCG;
            end
            ST_PCG: begin
                if (cnt_reg == (draw_reg ? 5'd5 : 5'd2)) begin
                    cnt_next   = '0;
                    state_next = draw_reg ? ST_NORM_INIT : ST_IDLE;
                end
            end
            ST_NORM_INIT: begin cnt_next = '0; state_next = ST_NORM; end
            ST_NORM: begin
                if (cnt_reg == 5'(NORM_STEPS - 1)) begin
                    cnt_next = '0; state_next = ST_LOG_INIT;
                end
            end
            ST_LOG_INIT: begin cnt_next = '0; state_next = ST_LOG; end
            ST_LOG: begin
                if (cnt_reg == 5'(LOG_STEPS - 1)) begin
                    cnt_next = '0; state_next = ST_VLO;
                end
            end
            ST_VLO:     begin cnt_next = '0; state_next = ST_VHI; end
            ST_VHI:     begin cnt_next = '0; state_next = ST_SQ_INIT; end
            ST_SQ_INIT: begin cnt_next = '0; state_next = ST_SQ; end
            ST_SQ: begin
                if (cnt_reg == 5'(SQ_STEPS - 1)) begin
                    cnt_next = '0; state_next = ST_ANG;
                end
            end
            ST_ANG: begin cnt_next = '0; state_next = ST_POW; end
            ST_POW: begin
                if (cnt_reg == 5'(POW_STEPS - 1)) begin
                    cnt_next = '0; state_next = ST_ACC_INIT;
                end
            end
            ST_ACC_INIT: begin cnt_next = '0; state_next = ST_DIV; end
            ST_DIV: begin
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    cnt_next = '0; state_next = ST_OUT_COS;
                end
            end
            ST_OUT_COS: begin cnt_next = '0; state_next = ST_OUT_SIN; end
            ST_OUT_SIN: begin cnt_next = '0; state_next = ST_DONE; end
            ST_DONE: begin
                cnt_next = '0;
                if (!out_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin cnt_next = '0; state_next = ST_IDLE; end
        endcase
    end

    // Outputs
    always_comb begin
        cmd.op   = OP_NONE;
        cmd.idx  = cnt_reg;
        cmd.take = (state_reg == ST_IDLE) && s_valid;
        push     = 1'b0;
        unique case (state_reg)
            ST_LOAD: cmd.op = OP_LOAD;
            ST_PCG: begin
                unique case (cnt_reg)
                    5'd0, 5'd3: cmd.op = OP_PCG0;
                    5'd1, 5'd4: cmd.op = OP_PCG1;
                    default:    cmd.op = OP_PCG2;
                endcase
            end
            ST_NORM_INIT: cmd.op = OP_NORM_INIT;
            ST_NORM:      cmd.op = OP_NORM;
            ST_LOG_INIT:  cmd.op = OP_LOG_INIT;
            ST_LOG:       cmd.op = OP_LOG;
            ST_VLO:       cmd.op = OP_VLO;
            ST_VHI:       cmd.op = OP_VHI;
            ST_SQ_INIT:   cmd.op = OP_SQ_INIT;
            ST_SQ:        cmd.op = OP_SQ;
            ST_ANG:       cmd.op = OP_ANG;
            ST_POW:       cmd.op = OP_POW;
            ST_ACC_INIT:  cmd.op = OP_ACC_INIT;
            ST_DIV:       cmd.op = OP_DIV;
            ST_OUT_COS:   cmd.op = OP_OUT_COS;
            ST_OUT_SIN:   cmd.op = OP_OUT_SIN;
            ST_DONE: begin
                push   = !out_valid_reg || m_ready;
                cmd.op = push ? OP_PUSH : OP_NONE;
            end
            default: cmd.op = OP_NONE;
        endcase
    end

    assign out_valid_next = push || (out_valid_reg && !m_ready);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

endmodule
`default_nettype wire

FILE: verif/gaussian_noise_pcg32_box_muller_top_tb.sv
// Self-checking testbench of the PCG32 / Box-Muller Gaussian noise source.
`default_nettype none
module gaussian_noise_pcg32_box_muller_top_tb import gnpb_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 1150;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 200;

    // One row of the directed table: a seed write ahead of the request when
    // wr_seed is set, and an optional typed-in result.
    typedef struct packed {
        logic        wr_seed;
        logic [63:0] seed_val;
        gnpb_req_t   req;
        logic        has_known;
        gnpb_res_t   known;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    gnpb_req_t   s_req;
    logic        m_valid;
    logic        m_ready;
    gnpb_res_t   m_res;
    logic        cfg_we;
    logic [63:0] cfg_wdata;

    // Predictor copy of the generator.
    logic [63:0] model_seed;
    logic [63:0] model_lcg;

    gnpb_res_t   pending_samples[$];
    int          error_count;
    int          result_count;
    int          draw_count;
    int          restart_count;
    longint      cycle_count;

    directed_row_t dir_rows[$];

    gaussian_noise_pcg32_box_muller_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Step the LCG and return one XSH-RR output word.
    function automatic logic [31:0] pcg_draw();
        logic [63:0] prev;
        logic [31:0] xs;
        logic [4:0]  rot;
        prev      = model_lcg;
        model_lcg = prev * PCG_MULT + PCG_INC;
        xs        = 32'(((prev >> 18) ^ prev) >> 27);
        rot       = prev[63:59];
        return (xs >> rot) | (xs << ((32 - rot) % 32));
    endfunction

    function automatic logic [63:0] q30_mul(logic [63:0] x, logic [63:0] y);
        return (x * y) >> 30;
    endfunction

    // -2 ln((a+1)/2^32) in Q30, log2 by repeated squaring.
    function automatic logic [63:0] neg_two_ln(logic [31:0] a);
        logic [63:0] x, m, frac, t, hi, lo;
        int          e;
        x    = 64'(a) + 64'd1;
        frac = '0;
        e    = 0;
        if (x >= (64'd1 << 32)) begin
            return 64'd0;
        end
        while (e < 31 && (x >> (e + 1)) != 0) e++;
        m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
        for (int i = 1; i <= 30; i++) begin
            m = q30_mul(m, m);
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac |= 64'd1 << (30 - i);
            end
        end
        t  = (64'(32 - e) << 30) - frac;
        hi = t >> 30;
        lo = t & 64'h3FFF_FFFF;
        return hi * 64'(TWO_LN2_Q30) + ((lo * 64'(TWO_LN2_Q30)) >> 30);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] root, b;
        root = '0;
        b    = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v    = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic longint unit_clamp(longint v);
        if (v < 0) return 0;
        if (v > longint'(Q30_ONE)) return longint'(Q30_ONE);
        return v;
    endfunction

    // Round half away from zero, then saturate to the output width.
    function automatic logic [OUT_WIDTH-1:0] scale_sample(logic [63:0] radius, longint trig);
        localparam int SH = 46 - FRAC_BITS;
        longint      maxv;
        logic [63:0] mag;
        longint      v;
        maxv = (longint'(1) << (OUT_WIDTH - 1)) - 1;
        mag  = radius * 64'(trig < 0 ? -trig : trig);
        mag  = (mag + (64'd1 << (SH - 1))) >> SH;
        if (trig < 0) begin
            v = (mag > 64'(maxv + 1)) ? -maxv - 1 : -longint'(mag);
        end else begin
            v = (mag > 64'(maxv)) ? maxv : longint'(mag);
        end
        return v[OUT_WIDTH-1:0];
    endfunction

    // Apply one accepted request to the predictor; queue the sample pair it yields.
    function automatic void predict_request(gnpb_req_t req);
        logic [31:0] a, b;
        logic [63:0] radius, w, r, x, x2, p3, p5, p7, p9, x4, x6, x8, x10;
        logic [2:0]  oct;
        longint      sn, cs, co, si;
        gnpb_res_t   res;
        if (req.req_type == REQ_RESTART) begin
            model_lcg = model_seed + SEED_OFFSET;
            void'(pcg_draw());
            restart_count++;
            return;
        end
        draw_count++;
        a      = pcg_draw();
        b      = pcg_draw();
        radius = int_sqrt(neg_two_ln(a) << 2);
        w      = {31'd0, b, 1'b1};
        oct    = w[32:30];
        r      = w & 64'h3FFF_FFFF;
        if (oct[0]) r = 64'(Q30_ONE) - r;
        x   = (r * 64'(PI_QTR_Q30)) >> 30;
        x2  = q30_mul(x, x);
        p3  = q30_mul(x, x2);
        p5  = q30_mul(p3, x2);
        p7  = q30_mul(p5, x2);
        p9  = q30_mul(p7, x2);
        x4  = q30_mul(x2, x2);
        x6  = q30_mul(x4, x2);
        x8  = q30_mul(x6, x2);
        x10 = q30_mul(x8, x2);
        sn  = unit_clamp(longint'(x) - longint'(p3 / 6) + longint'(p5 / 120)
                         - longint'(p7 / 5040) + longint'(p9 / 362880));
        cs  = unit_clamp(longint'(Q30_ONE) - longint'(x2 / 2) + longint'(x4 / 24)
                         - longint'(x6 / 720) + longint'(x8 / 40320)
                         - longint'(x10 / 3628800));
        case (oct)
            3'd0: begin co = cs;  si = sn;  end
            3'd1: begin co = sn;  si = cs;  end
            3'd2: begin co = -sn; si = cs;  end
            3'd3: begin co = -cs; si = sn;  end
            3'd4: begin co = -cs; si = -sn; end
            3'd5: begin co = -sn; si = -cs; end
            3'd6: begin co = sn;  si = -cs; end
            default: begin co = cs; si = -sn; end
        endcase
        res.sample_cos   = scale_sample(radius, co);
        res.sample_sin   = req.odd_tail ? '0 : scale_sample(radius, si);
        res.second_valid = ~req.odd_tail;
        pending_samples.push_back(res);
    endfunction

    // Hold one request until accepted, after a random gap. Valid is dropped
    // only for a gap; with no gap the next request follows directly.
    task automatic send_request(gnpb_req_t req, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(req);
    endtask

    // Drop valid, wait for every pending result, give the block time to
    // finish a restart, then write the seed while idle.
    task automatic write_seed(logic [63:0] value);
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        model_seed = value;
    endtask

    // Result side: random stall per result, compare with oldest pending.
    initial begin
        gnpb_res_t want;
        int        stall;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = $urandom_range(0, 19);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            result_count++;
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_res);
                error_count++;
            end else begin
                want = pending_samples.pop_front();
                if (m_res.sample_cos !== want.sample_cos) begin
                    $display("%0t: sample_cos expected %0d actual %0d",
                             $time, want.sample_cos, m_res.sample_cos);
                    error_count++;
                end
                if (m_res.sample_sin !== want.sample_sin) begin
                    $display("%0t: sample_sin expected %0d actual %0d",
                             $time, want.sample_sin, m_res.sample_sin);
                    error_count++;
                end
                if (m_res.second_valid !== want.second_valid) begin
                    $display("%0t: second_valid expected %0b actual %0b",
                             $time, want.second_valid, m_res.second_valid);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results pending",
                         cycle_count, pending_samples.size());
                $display("FAIL gaussian_noise_pcg32_box_muller_top");
                $finish;
            end
        end
    end

    initial begin
        directed_row_t row;
        gnpb_req_t     req;
        gnpb_res_t     zero_res;
        int            gap;
        int            phase_len;
        logic [63:0]   seed_pick;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_req       = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        model_seed  = '0;
        model_lcg   = '0;
        error_count = 0;
        result_count  = 0;
        draw_count    = 0;
        restart_count = 0;
        zero_res    = '0;

        // Directed table. After reset the state is zero, so the first draw
        // comes from a zero state (a = 0, the radius is largest).
        dir_rows.push_back('{1'b0, 64'd0, '{REQ_DRAW, 1'b0}, 1'b0, zero_res});
        dir_rows.push_back('{1'b0, 64'd0, '{REQ_DRAW, 1'b1}, 1'b0, zero_res});
        // Restart ignores odd_tail and yields nothing.
        dir_rows.push_back('{1'b0, 64'd0, '{REQ_RESTART, 1'b1}, 1'b0, zero_res});
        dir_rows.push_back('{1'b0, 64'd0, '{REQ_DRAW, 1'b0}, 1'b0, zero_res});
        dir_rows.push_back('{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, '{REQ_RESTART, 1'b0},
                             1'b0, zero_res});
        dir_rows.push_back('{1'b0, 64'd0, '{REQ_DRAW, 1'b1}, 1'b0, zero_res});
        dir_rows.push_back('{1'b0, 64'd0, '{REQ_DRAW, 1'b0}, 1'b0, zero_res});
        // Seed that cancels the offset: restart loads zero, advances once.
        dir_rows.push_back('{1'b1, 64'd0 - SEED_OFFSET, '{REQ_RESTART, 1'b0},
                             1'b0, zero_res});
        for (int i = 0; i < 6; i++) begin
            dir_rows.push_back('{1'b0, 64'd0, '{REQ_DRAW, 1'(i % 2)}, 1'b0, zero_res});
        end
        dir_rows.push_back('{1'b1, 64'h5555_AAAA_5555_AAAA, '{REQ_RESTART, 1'b0},
                             1'b0, zero_res});
        for (int i = 0; i < 6; i++) begin
            dir_rows.push_back('{1'b0, 64'd0, '{REQ_DRAW, 1'(i / 3)}, 1'b0, zero_res});
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.wr_seed) write_seed(row.seed_val);
            send_request(row.req, $urandom_range(0, 19));
            if (row.has_known && pending_samples.size() != 0) begin
                pending_samples[$] = row.known;
            end
        end

        // Random phases: seed write, restart, then mostly draws with noise
        // restarts, each after a random idle gap.
        for (int n = 0; n < RANDOM_REQUESTS; n += phase_len) begin
            phase_len = $urandom_range(40, 120);
            case ($urandom_range(0, 4))
                0: seed_pick = 64'd0;
                1: seed_pick = '1;
                default: seed_pick = {$urandom, $urandom};
            endcase
            write_seed(seed_pick);
            send_request('{REQ_RESTART, 1'($urandom_range(0, 1))}, 0);
            for (int k = 0; k < phase_len; k++) begin
                req.req_type = ($urandom_range(0, 19) == 0) ? REQ_RESTART : REQ_DRAW;
                req.odd_tail = 1'($urandom_range(0, 1));
                gap = $urandom_range(0, 19);
                send_request(req, gap);
            end
        end

        // Hold off until the output side has drained everything.
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d draws and %0d restarts, %0d results checked,",
                 draw_count, restart_count, result_count);
        $display("seeds at zero, all ones and random, odd tails and stalls on both sides.");
        if (error_count == 0) begin
            $display("PASS gaussian_noise_pcg32_box_muller_top");
        end else begin
            $display("FAIL gaussian_noise_pcg32_box_muller_top");
        end
        $finish;
    end

endmodule
`default_nettype wire
